>>> design/tty_line_discipline_rings_defines.svh
// Assertion macros for the terminal line discipline block
`ifndef TTY_LINE_DISCIPLINE_RINGS_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_RINGS_DEFINES_SVH
// Implication checked on every clock edge out of reset
`define TLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tld check failed");
// Invariant checked on every clock edge out of reset
`define TLD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tld check failed");
`endif

>>> design/tld_pkg.sv
// Shared types and constants of the terminal line discipline
`timescale 1ns / 1ps
`default_nettype none
package tld_pkg;
  localparam logic [2:0] ACT_MWRITE = 3'd0;
  localparam logic [2:0] ACT_SWRITE = 3'd1;
  localparam logic [2:0] ACT_MREAD  = 3'd2;
  localparam logic [2:0] ACT_SREAD  = 3'd3;
  localparam logic [2:0] ACT_MFLUSH = 3'd4;
  localparam logic [2:0] ACT_SFLUSH = 3'd5;

  localparam logic [2:0] CFG_INPUT  = 3'd0;
  localparam logic [2:0] CFG_OUTPUT = 3'd1;
  localparam logic [2:0] CFG_LOCAL  = 3'd2;
  localparam logic [2:0] CFG_ERASE  = 3'd3;
  localparam logic [2:0] CFG_KILL   = 3'd4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Ring selection for datapath commands
  typedef enum logic {RING_TM = 1'b0, RING_TS = 1'b1} ring_sel_t;

  // Controller to datapath command
  typedef struct packed {
    logic      push;      // write push_byte at tail of ring
    logic      pop;       // read at head, advance head
    logic      rd_last;   // read entry before tail of ring
    logic      drop_last; // step tail back one (to-slave ring only)
    logic      flush;
    ring_sel_t ring;
    logic [7:0] push_byte;
  } tld_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       tm_empty;
    logic       tm_free1; // at least one free slot
    logic       tm_free2; // at least two free slots
    logic       ts_empty;
    logic       ts_full;
    logic [7:0] rd_data;  // registered memory read
  } tld_stat_t;
endpackage
`default_nettype wire

>>> design/tty_line_discipline_rings.sv
// Top level of the terminal line discipline between two byte rings
// Each item is decoded in S_DECODE and then walks the states that its action needs until
// S_DONE raises out_valid: a read waits for the registered byte, a write with echo pushes
// its echo bytes, an erase reads the last to-slave byte and, unless the ring is empty or
// the byte ends a line, drops it with BS SP BS echo (none without echo), and a kill repeats
// this back to the start of the line. Echo bytes are dropped once the to-master ring is
// full. The last byte is read through the registered read port that both ring stores
// share. Results sit in an output register; a new item is taken the cycle after that
// result has been delivered. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
`include "tty_line_discipline_rings_defines.svh"
module tty_line_discipline_rings #(
  parameter int RING_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic             out_read_valid,
  output logic [7:0]       out_read_byte,
  output logic [11:0]      out_to_master_level,
  output logic [11:0]      out_to_slave_level,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  tld_pkg::tld_cmd_t  cmd;
  tld_pkg::tld_stat_t stat;

  tld_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_data_byte,
    .out_valid, .out_ready, .out_accepted, .out_read_valid, .out_read_byte,
    .cfg_we, .cfg_index, .cfg_data, .cmd, .stat
  );

  tld_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .tm_level(out_to_master_level), .ts_level(out_to_slave_level)
  );

  `TLD_ASSERT_ALWAYS(a_no_accept_busy, !(in_ready && out_valid))
  `TLD_ASSERT_IMP(a_rv_acc_excl, out_valid, !(out_accepted && out_read_valid))
  `TLD_ASSERT_IMP(a_no_push_full, cmd.push && cmd.ring == tld_pkg::RING_TM, stat.tm_free1)
endmodule
`default_nettype wire

>>> design/tld_datapath.sv
// Ring stores, pointers and counts of the line discipline
`timescale 1ns / 1ps
`default_nettype none
module tld_datapath #(
  parameter int RING_DEPTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tld_pkg::tld_cmd_t cmd,
  output tld_pkg::tld_stat_t    stat,
  output logic [11:0]           tm_level,
  output logic [11:0]           ts_level
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] CAP  = CW'(RING_DEPTH - 1);

  logic [7:0] tm_mem [RING_DEPTH];
  logic [7:0] ts_mem [RING_DEPTH];
  logic [AW-1:0] tm_head_r, tm_tail_r, ts_head_r, ts_tail_r;
  logic [CW-1:0] tm_cnt_r, ts_cnt_r;
  logic [7:0] rd_r;

  logic [AW-1:0] head_sel, tail_sel, addr_rd, tail_prev;
  logic sel_ts;

  assign sel_ts    = (cmd.ring == tld_pkg::RING_TS);
  assign head_sel  = sel_ts ? ts_head_r : tm_head_r;
  assign tail_sel  = sel_ts ? ts_tail_r : tm_tail_r;
  assign tail_prev = (tail_sel == '0) ? LAST : tail_sel - 1'b1;
  assign addr_rd   = cmd.rd_last ? tail_prev : head_sel;

  // Write and read both memories
  always_ff @(posedge clk) begin
    if (cmd.push && !sel_ts) tm_mem[tm_tail_r] <= cmd.push_byte;
    if (cmd.push && sel_ts)  ts_mem[ts_tail_r] <= cmd.push_byte;
    rd_r <= sel_ts ? ts_mem[addr_rd] : tm_mem[addr_rd];
  end

  // Advance pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_head_r <= '0; tm_tail_r <= '0; tm_cnt_r <= '0;
      ts_head_r <= '0; ts_tail_r <= '0; ts_cnt_r <= '0;
    end else if (!sel_ts) begin
      if (cmd.flush) begin
        tm_head_r <= '0; tm_tail_r <= '0; tm_cnt_r <= '0;
      end else if (cmd.push) begin
        tm_tail_r <= (tm_tail_r == LAST) ? '0 : tm_tail_r + 1'b1;
        tm_cnt_r  <= tm_cnt_r + 1'b1;
      end else if (cmd.pop) begin
        tm_head_r <= (tm_head_r == LAST) ? '0 : tm_head_r + 1'b1;
        tm_cnt_r  <= tm_cnt_r - 1'b1;
      end
    end else begin
      if (cmd.flush) begin
        ts_head_r <= '0; ts_tail_r <= '0; ts_cnt_r <= '0;
      end else if (cmd.push) begin
        ts_tail_r <= (ts_tail_r == LAST) ? '0 : ts_tail_r + 1'b1;
        ts_cnt_r  <= ts_cnt_r + 1'b1;
      end else if (cmd.pop) begin
        ts_head_r <= (ts_head_r == LAST) ? '0 : ts_head_r + 1'b1;
        ts_cnt_r  <= ts_cnt_r - 1'b1;
      end else if (cmd.drop_last) begin
        ts_tail_r <= tail_prev;
        ts_cnt_r  <= ts_cnt_r - 1'b1;
      end
    end
  end

  assign stat.tm_empty = (tm_cnt_r == '0);
  assign stat.tm_free1 = (tm_cnt_r < CAP);
  assign stat.tm_free2 = (tm_cnt_r < CAP - 1'b1);
  assign stat.ts_empty = (ts_cnt_r == '0);
  assign stat.ts_full  = (ts_cnt_r >= CAP);
  assign stat.rd_data  = rd_r;
  assign tm_level = 12'(tm_cnt_r);
  assign ts_level = 12'(ts_cnt_r);
endmodule
`default_nettype wire

>>> design/tld_ctrl.sv
// Sequencer of the line discipline: decodes items and issues ring commands
`timescale 1ns / 1ps
`default_nettype none
module tld_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_action,
  input  wire logic [7:0]        in_data_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_accepted,
  output logic                   out_read_valid,
  output logic [7:0]             out_read_byte,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output tld_pkg::tld_cmd_t      cmd,
  input  wire tld_pkg::tld_stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_WAIT, S_ER_RD, S_ER_WAIT, S_ER_CHK,
    S_EMIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] imode_r, omode_r;
  logic [4:0] lmode_r;
  logic [7:0] erase_r, kill_r;
  logic [2:0] act_r, act_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       kill_mode_r, kill_mode_nxt;
  // Pending emit bytes: up to three, with a count of those still to push
  logic [7:0] em0_r, em1_r, em2_r, em0_nxt, em1_nxt, em2_nxt;
  logic [1:0] em_n_r, em_n_nxt;
  logic       acc_r, acc_nxt, rv_r, rv_nxt, ov_r, ov_nxt;
  logic [7:0] rb_r, rb_nxt;

  logic [7:0] mapped;
  logic       canon, echo_on, do_echo, caret;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imode_r <= 3'd2; omode_r <= 3'd3; lmode_r <= 5'd7;
      erase_r <= 8'd127; kill_r <= 8'd21;
    end else if (cfg_we) begin
      case (cfg_index)
        tld_pkg::CFG_INPUT:  imode_r <= cfg_data[2:0];
        tld_pkg::CFG_OUTPUT: omode_r <= cfg_data[2:0];
        tld_pkg::CFG_LOCAL:  lmode_r <= cfg_data[4:0];
        tld_pkg::CFG_ERASE:  erase_r <= cfg_data;
        tld_pkg::CFG_KILL:   kill_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input mapping of a master byte
  always_comb begin
    mapped = byte_r;
    if (imode_r[1] && byte_r == tld_pkg::CH_CR) mapped = tld_pkg::CH_LF;
    else if (imode_r[2] && byte_r == tld_pkg::CH_LF) mapped = tld_pkg::CH_CR;
  end
  assign canon   = lmode_r[0];
  assign echo_on = lmode_r[1] && lmode_r[2];
  assign caret   = lmode_r[4];
  assign do_echo = lmode_r[1] || (lmode_r[3] && mapped == tld_pkg::CH_LF);

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_accepted = acc_r;
  assign out_read_valid = rv_r;
  assign out_read_byte = rb_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; byte_nxt = byte_r; kill_mode_nxt = kill_mode_r;
    em0_nxt = em0_r; em1_nxt = em1_r; em2_nxt = em2_r; em_n_nxt = em_n_r;
    acc_nxt = acc_r; rv_nxt = rv_r; rb_nxt = rb_r; ov_nxt = ov_r;
    cmd = '0;
    cmd.ring = tld_pkg::RING_TM;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt = in_action; byte_nxt = in_data_byte;
          acc_nxt = 1'b0; rv_nxt = 1'b0; rb_nxt = '0;
          kill_mode_nxt = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (act_r)
          tld_pkg::ACT_MWRITE: begin
            acc_nxt = 1'b1;
            if (imode_r[0] && byte_r == tld_pkg::CH_CR) begin
              state_nxt = S_DONE;
            end else if (canon && erase_r != 8'd0 && mapped == erase_r) begin
              kill_mode_nxt = 1'b0; state_nxt = S_ER_RD;
            end else if (canon && kill_r != 8'd0 && mapped == kill_r) begin
              kill_mode_nxt = 1'b1; state_nxt = S_ER_RD;
            end else if (stat.ts_full) begin
              acc_nxt = 1'b0;
            end else begin
              cmd.push = 1'b1; cmd.ring = tld_pkg::RING_TS; cmd.push_byte = mapped;
              em_n_nxt = 2'd0;
              if (do_echo) begin
                state_nxt = S_EMIT;
                if (caret && mapped < 8'd32 && mapped != tld_pkg::CH_TAB &&
                    mapped != tld_pkg::CH_LF && mapped != tld_pkg::CH_CR) begin
                  em0_nxt = tld_pkg::CH_CARET; em1_nxt = mapped + 8'd64;
                  em_n_nxt = 2'd2;
                end else if (caret && mapped == tld_pkg::CH_DEL) begin
                  em0_nxt = tld_pkg::CH_CARET; em1_nxt = tld_pkg::CH_QUEST;
                  em_n_nxt = 2'd2;
                end else if (omode_r[0] && omode_r[1] && mapped == tld_pkg::CH_LF) begin
                  if (stat.tm_free2) begin
                    em0_nxt = tld_pkg::CH_CR; em1_nxt = tld_pkg::CH_LF;
                    em_n_nxt = 2'd2;
                  end
                end else if (stat.tm_free1) begin
                  em0_nxt = (omode_r[0] && omode_r[2] && mapped == tld_pkg::CH_CR)
                            ? tld_pkg::CH_LF : mapped;
                  em_n_nxt = 2'd1;
                end
              end
            end
          end
          tld_pkg::ACT_SWRITE: begin
            if (omode_r[0] && omode_r[1] && byte_r == tld_pkg::CH_LF) begin
              if (stat.tm_free2) begin
                acc_nxt = 1'b1; cmd.push = 1'b1; cmd.push_byte = tld_pkg::CH_CR;
                em0_nxt = tld_pkg::CH_LF; em_n_nxt = 2'd1; state_nxt = S_EMIT;
              end
            end else if (stat.tm_free1) begin
              acc_nxt = 1'b1; cmd.push = 1'b1;
              cmd.push_byte = (omode_r[0] && omode_r[2] && byte_r == tld_pkg::CH_CR)
                              ? tld_pkg::CH_LF : byte_r;
            end
          end
          tld_pkg::ACT_MREAD: begin
            if (!stat.tm_empty) begin
              cmd.pop = 1'b1; rv_nxt = 1'b1; state_nxt = S_POP_WAIT;
            end
          end
          tld_pkg::ACT_SREAD: begin
            if (!stat.ts_empty) begin
              cmd.pop = 1'b1; cmd.ring = tld_pkg::RING_TS;
              rv_nxt = 1'b1; state_nxt = S_POP_WAIT;
            end
          end
          tld_pkg::ACT_MFLUSH: cmd.flush = 1'b1;
          tld_pkg::ACT_SFLUSH: begin
            cmd.flush = 1'b1; cmd.ring = tld_pkg::RING_TS;
          end
          default: ;
        endcase
      end
      S_POP_WAIT: begin
        rb_nxt = stat.rd_data; state_nxt = S_DONE;
      end
      // Read the last to-slave byte
      S_ER_RD: begin
        cmd.ring = tld_pkg::RING_TS; cmd.rd_last = 1'b1;
        state_nxt = stat.ts_empty ? S_DONE : S_ER_WAIT;
      end
      S_ER_WAIT: begin
        cmd.ring = tld_pkg::RING_TS; cmd.rd_last = 1'b1;
        state_nxt = S_ER_CHK;
      end
      S_ER_CHK: begin
        if (stat.rd_data == tld_pkg::CH_LF) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ring = tld_pkg::RING_TS; cmd.drop_last = 1'b1;
          em0_nxt = tld_pkg::CH_BS; em1_nxt = tld_pkg::CH_SP;
          em2_nxt = tld_pkg::CH_BS;
          em_n_nxt = echo_on ? 2'd3 : 2'd0;
          state_nxt = S_EMIT;
        end
      end
      // Push echo bytes one a cycle, drop the rest once full
      S_EMIT: begin
        if (em_n_r == 2'd0 || !stat.tm_free1) begin
          em_n_nxt = 2'd0;
          // Keep walking back through the line while a kill is running
          state_nxt = kill_mode_r ? S_ER_RD : S_DONE;
        end else begin
          cmd.push = 1'b1; cmd.push_byte = em0_r;
          em0_nxt = em1_r; em1_nxt = em2_r; em_n_nxt = em_n_r - 2'd1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; kill_mode_r <= 1'b0; em_n_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; kill_mode_r <= kill_mode_nxt;
      em_n_r <= em_n_nxt;
    end
    act_r <= act_nxt; byte_r <= byte_nxt;
    em0_r <= em0_nxt; em1_r <= em1_nxt; em2_r <= em2_nxt;
    acc_r <= acc_nxt; rv_r <= rv_nxt; rb_r <= rb_nxt;
  end
endmodule
`default_nettype wire
